/* rtl/core/assert_macros.svh */
// Assertion macros for the vertical non-maximum suppression block.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a complete property on every rising clock edge outside reset.
`define VNMS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checks that the consequent holds in every cycle where the antecedent holds.
`define VNMS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* rtl/core/vnms_pkg.sv */
// Shared types and constants for the vertical non-maximum suppression block.
// Used by vnms_pixel_ram and vertical_non_max_suppression; depends on nothing.
`default_nettype none

package vnms_pkg;

  localparam int unsigned MaxWidth   = 256;
  localparam int unsigned MaxHeight  = 256;
  localparam int unsigned WeightBits = 16;

  localparam int unsigned CfgAw = 2;
  localparam int unsigned CfgDw = 9;

  localparam logic [CfgDw-1:0] ImageWidthRst = 9'd256;
  localparam logic [CfgDw-1:0] ColStartRst   = 9'd0;
  localparam logic [CfgDw-1:0] ColEndRst     = 9'd256;

  typedef enum logic [1:0] {
    OP_WRITE    = 2'd0,
    OP_READ     = 2'd1,
    OP_SUPPRESS = 2'd2
  } op_e;

  typedef enum logic [CfgAw-1:0] {
    REG_IMAGE_WIDTH = 2'd0,
    REG_COL_START   = 2'd1,
    REG_COL_END     = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_COL_RD,
    ST_COL_CHK,
    ST_SPAN_RD,
    ST_SPAN_CMP,
    ST_CLEAR,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [15:0] read_weight;
    logic        read_flag;
    logic [8:0]  candidates;
    logic [8:0]  kept;
    logic        status;
  } result_t;

endpackage

`default_nettype wire

/* rtl/core/vnms_pixel_ram.sv */
// Single-port pixel store with registered read data.
// Depends on vnms_pkg for the default geometry.
`default_nettype none

module vnms_pixel_ram #(
  parameter int unsigned ADDR_W = $clog2(vnms_pkg::MaxWidth) + $clog2(vnms_pkg::MaxHeight),
  parameter int unsigned DATA_W = vnms_pkg::WeightBits + 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] addr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  output logic      [DATA_W-1:0] rdata_o
);

  localparam int unsigned Depth = 2 ** ADDR_W;

  logic [DATA_W-1:0] mem_q [Depth];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/core/vertical_non_max_suppression.sv */
// Top level of the vertical non-maximum suppression block: sequencer and datapath.
// Depends on vnms_pkg, vnms_pixel_ram and assert_macros.svh.
`default_nettype none
// Usage: a command word is taken at a rising edge with start_i high and busy_o low.
// operation_i selects a pixel write, a pixel read or the suppression of one row.
// Each command gives one result word, shown for one cycle with done_o high; the
// receiver cannot stall, so it must take the word in that cycle.
// Configuration registers are written through cfg_we_i, cfg_index_i and cfg_wdata_i
// while the block is idle; a write takes effect at once.
// A write or a rejected command reports in the cycle after it is taken; a read
// first passes its read state. A suppress visits a read and a check state per
// scanned column; per flagged column, a read and a compare state per span row other
// than the suppressed row (stopping at the first heavier pixel), a read state for the
// suppressed row when the walk reaches it and a clear state to clear a lost flag.
// A flagged pixel of weight zero skips the span walk and only clears its flag.
// Every step goes through the single port of the pixel store, one access each
// cycle, and one weight comparator does all the comparisons.
// A read or a suppress holds busy_o high until the edge that puts its result
// word out; a write leaves busy_o low, so the next word can follow at once.
// Reset returns the sequencer to idle and the registers to full width and the
// full column range; the pixel store is not cleared and must be written first.
`include "assert_macros.svh"

module vertical_non_max_suppression #(
  parameter int unsigned MAX_WIDTH   = vnms_pkg::MaxWidth,
  parameter int unsigned MAX_HEIGHT  = vnms_pkg::MaxHeight,
  parameter int unsigned WEIGHT_BITS = vnms_pkg::WeightBits
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [vnms_pkg::CfgAw-1:0] cfg_index_i,
  input  wire logic [vnms_pkg::CfgDw-1:0] cfg_wdata_i,
  input  wire logic                       start_i,
  output logic                            busy_o,
  input  wire logic [1:0]                 operation_i,
  input  wire logic [7:0]                 row_i,
  input  wire logic [7:0]                 col_i,
  input  wire logic [15:0]                weight_i,
  input  wire logic                       flag_i,
  input  wire logic [7:0]                 row_first_i,
  input  wire logic [7:0]                 row_last_i,
  output logic                            done_o,
  output logic [15:0]                     read_weight_o,
  output logic                            read_flag_o,
  output logic [8:0]                      candidates_o,
  output logic [8:0]                      kept_o,
  output logic                            status_o
);

  localparam int unsigned RowAw   = $clog2(MAX_HEIGHT);
  localparam int unsigned ColAw   = $clog2(MAX_WIDTH);
  localparam int unsigned AddrW   = RowAw + ColAw;
  localparam int unsigned DataW   = WEIGHT_BITS + 1;
  localparam int unsigned LastRow = MAX_HEIGHT - 1;

  vnms_pkg::state_e  state_q, state_d;
  vnms_pkg::result_t result_q, result_d;
  logic              done_q, done_d;

  logic [8:0] image_width_q, col_start_q, col_end_q;

  logic [7:0]             row_q, row_d;
  logic [7:0]             rfirst_q, rfirst_d;
  logic [7:0]             last_q, last_d;
  logic [7:0]             span_q, span_d;
  logic [8:0]             end_q, end_d;
  logic [8:0]             col_q, col_d;
  logic [8:0]             cand_q, cand_d;
  logic [8:0]             kept_q, kept_d;
  logic [WEIGHT_BITS-1:0] cur_q, cur_d;

  logic             mem_we;
  logic [AddrW-1:0] mem_addr;
  logic [DataW-1:0] mem_wdata;
  logic [DataW-1:0] mem_rdata;

  logic [WEIGHT_BITS-1:0] rd_weight;
  logic                   rd_flag;
  logic [8:0]             width_use;
  logic [8:0]             end_col;
  logic [7:0]             last_row;
  logic                   row_ok;
  logic                   pix_ok;
  logic [8:0]             col_next;
  logic                   col_last;
  logic                   span_empty;
  logic                   span_end;
  logic                   span_self;
  logic                   heavier;

  assign rd_weight = mem_rdata[WEIGHT_BITS-1:0];
  assign rd_flag   = mem_rdata[WEIGHT_BITS];

  assign width_use = (32'(image_width_q) > MAX_WIDTH) ? 9'(MAX_WIDTH) : image_width_q;
  assign end_col   = (col_end_q < width_use) ? col_end_q : width_use;
  assign last_row  = (32'(row_last_i) > LastRow) ? 8'(LastRow) : row_last_i;
  assign row_ok    = 32'(row_i) < MAX_HEIGHT;
  assign pix_ok    = row_ok && ({1'b0, col_i} < width_use);

  assign col_next   = col_q + 9'd1;
  assign col_last   = col_next == end_q;
  assign span_empty = rfirst_q > last_q;
  assign span_end   = span_q == last_q;
  assign span_self  = span_q == row_q;
  assign heavier    = rd_weight > cur_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q <= vnms_pkg::ImageWidthRst;
      col_start_q   <= vnms_pkg::ColStartRst;
      col_end_q     <= vnms_pkg::ColEndRst;
    end else if (cfg_we_i) begin
      unique case (vnms_pkg::cfg_reg_e'(cfg_index_i))
        vnms_pkg::REG_IMAGE_WIDTH: image_width_q <= cfg_wdata_i;
        vnms_pkg::REG_COL_START:   col_start_q   <= cfg_wdata_i;
        vnms_pkg::REG_COL_END:     col_end_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      vnms_pkg::ST_IDLE: begin
        if (start_i) begin
          if (operation_i == vnms_pkg::OP_READ && pix_ok) begin
            state_d = vnms_pkg::ST_READ;
          end else if (operation_i == vnms_pkg::OP_SUPPRESS && row_ok) begin
            state_d = (col_start_q < end_col) ? vnms_pkg::ST_COL_RD : vnms_pkg::ST_DONE;
          end
        end
      end
      vnms_pkg::ST_READ: state_d = vnms_pkg::ST_IDLE;
      vnms_pkg::ST_COL_RD: state_d = vnms_pkg::ST_COL_CHK;
      vnms_pkg::ST_COL_CHK: begin
        if (rd_flag && rd_weight == '0) begin
          state_d = vnms_pkg::ST_CLEAR;
        end else if (rd_flag && !span_empty) begin
          state_d = vnms_pkg::ST_SPAN_RD;
        end else begin
          state_d = col_last ? vnms_pkg::ST_DONE : vnms_pkg::ST_COL_RD;
        end
      end
      vnms_pkg::ST_SPAN_RD: begin
        if (!span_self) begin
          state_d = vnms_pkg::ST_SPAN_CMP;
        end else if (span_end) begin
          state_d = col_last ? vnms_pkg::ST_DONE : vnms_pkg::ST_COL_RD;
        end
      end
      vnms_pkg::ST_SPAN_CMP: begin
        if (heavier) begin
          state_d = vnms_pkg::ST_CLEAR;
        end else if (span_end) begin
          state_d = col_last ? vnms_pkg::ST_DONE : vnms_pkg::ST_COL_RD;
        end else begin
          state_d = vnms_pkg::ST_SPAN_RD;
        end
      end
      vnms_pkg::ST_CLEAR: state_d = col_last ? vnms_pkg::ST_DONE : vnms_pkg::ST_COL_RD;
      vnms_pkg::ST_DONE: state_d = vnms_pkg::ST_IDLE;
      default: state_d = vnms_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    row_d     = row_q;
    rfirst_d  = rfirst_q;
    last_d    = last_q;
    span_d    = span_q;
    end_d     = end_q;
    col_d     = col_q;
    cand_d    = cand_q;
    kept_d    = kept_q;
    cur_d     = cur_q;
    result_d  = result_q;
    done_d    = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = {RowAw'(row_q), ColAw'(col_q)};
    mem_wdata = {1'b0, cur_q};
    unique case (state_q)
      vnms_pkg::ST_IDLE: begin
        mem_addr = {RowAw'(row_i), ColAw'(col_i)};
        if (start_i) begin
          case (vnms_pkg::op_e'(operation_i))
            vnms_pkg::OP_WRITE: begin
              mem_we          = pix_ok;
              mem_wdata       = {flag_i, WEIGHT_BITS'(weight_i)};
              result_d        = '0;
              result_d.status = !pix_ok;
              done_d          = 1'b1;
            end
            vnms_pkg::OP_READ: begin
              if (!pix_ok) begin
                result_d        = '0;
                result_d.status = 1'b1;
                done_d          = 1'b1;
              end
            end
            vnms_pkg::OP_SUPPRESS: begin
              if (!row_ok) begin
                result_d        = '0;
                result_d.status = 1'b1;
                done_d          = 1'b1;
              end else begin
                row_d    = row_i;
                rfirst_d = row_first_i;
                last_d   = last_row;
                end_d    = end_col;
                col_d    = col_start_q;
                cand_d   = '0;
                kept_d   = '0;
              end
            end
            default: begin
              result_d        = '0;
              result_d.status = 1'b1;
              done_d          = 1'b1;
            end
          endcase
        end
      end
      vnms_pkg::ST_READ: begin
        result_d             = '0;
        result_d.read_weight = 16'(rd_weight);
        result_d.read_flag   = rd_flag;
        done_d               = 1'b1;
      end
      vnms_pkg::ST_COL_RD: ;
      vnms_pkg::ST_COL_CHK: begin
        if (!rd_flag) begin
          col_d = col_next;
        end else begin
          cand_d = cand_q + 9'd1;
          cur_d  = rd_weight;
          if (rd_weight != '0) begin
            if (span_empty) begin
              kept_d = kept_q + 9'd1;
              col_d  = col_next;
            end else begin
              span_d = rfirst_q;
            end
          end
        end
      end
      vnms_pkg::ST_SPAN_RD: begin
        mem_addr = {RowAw'(span_q), ColAw'(col_q)};
        if (span_self) begin
          if (span_end) begin
            kept_d = kept_q + 9'd1;
            col_d  = col_next;
          end else begin
            span_d = span_q + 8'd1;
          end
        end
      end
      vnms_pkg::ST_SPAN_CMP: begin
        if (!heavier) begin
          if (span_end) begin
            kept_d = kept_q + 9'd1;
            col_d  = col_next;
          end else begin
            span_d = span_q + 8'd1;
          end
        end
      end
      vnms_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
        col_d  = col_next;
      end
      vnms_pkg::ST_DONE: begin
        result_d            = '0;
        result_d.candidates = cand_q;
        result_d.kept       = kept_q;
        done_d              = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vnms_pkg::ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q    <= row_d;
    rfirst_q <= rfirst_d;
    last_q   <= last_d;
    span_q   <= span_d;
    end_q    <= end_d;
    col_q    <= col_d;
    cand_q   <= cand_d;
    kept_q   <= kept_d;
    cur_q    <= cur_d;
    result_q <= result_d;
  end

  vnms_pixel_ram #(
    .ADDR_W(AddrW),
    .DATA_W(DataW)
  ) u_pixel_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .addr_i (mem_addr),
    .wdata_i(mem_wdata),
    .rdata_o(mem_rdata)
  );

  assign busy_o        = state_q != vnms_pkg::ST_IDLE;
  assign done_o        = done_q;
  assign read_weight_o = result_q.read_weight;
  assign read_flag_o   = result_q.read_flag;
  assign candidates_o  = result_q.candidates;
  assign kept_o        = result_q.kept;
  assign status_o      = result_q.status;

  // A rejected command reports nothing but its error status.
  `VNMS_ASSERT_IMPL(a_error_clean, done_o && status_o,
    read_weight_o == '0 && !read_flag_o && candidates_o == '0 && kept_o == '0,
    "error result carries data")

  // Survivors are a subset of the candidates found.
  `VNMS_ASSERT(a_kept_le_cand, done_o |-> kept_o <= candidates_o, "kept exceeds candidates")

  // The span walk stays inside the scanned columns and the span rows.
  `VNMS_ASSERT_IMPL(a_span_bounds,
    state_q == vnms_pkg::ST_SPAN_RD || state_q == vnms_pkg::ST_SPAN_CMP,
    col_q < end_q && span_q <= last_q && rfirst_q <= last_q,
    "span walk out of bounds")

  // The pixel store is written only by a write command or a flag clear.
  `VNMS_ASSERT_IMPL(a_store_write, mem_we,
    state_q == vnms_pkg::ST_CLEAR || (state_q == vnms_pkg::ST_IDLE && start_i),
    "unexpected pixel store write")

endmodule

`default_nettype wire
